// File: src/itp_pkg.sv
package itp_pkg;

	// Stack geometry.
	localparam int STACK_DEPTH = 32;
	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);

	// Depth of the command queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Token codes.
	localparam logic [2:0] PRI_NUMBER = 3'd0;
	localparam logic [2:0] PRI_OP_MAX = 3'd3;
	localparam logic [2:0] PRI_FUNCTION = 3'd4;
	localparam logic [4:0] TYPE_OPEN = 5'd16;
	localparam logic [4:0] TYPE_CLOSE = 5'd17;

	// Command kinds decided by the front.
	typedef logic [2:0] kind_t;
	localparam kind_t KIND_EMIT = 3'd0;
	localparam kind_t KIND_PUSH = 3'd1;
	localparam kind_t KIND_OPER = 3'd2;
	localparam kind_t KIND_CLOSE = 3'd3;
	localparam kind_t KIND_IGNORE = 3'd4;

	// One classified request as it travels through the queue.
	typedef struct packed {
		kind_t       kind;
		logic [63:0] value;
		logic [2:0]  pri;
		logic [4:0]  typ;
		logic        last;
	} cmd_t;

	// One stack entry.
	typedef struct packed {
		logic [63:0] value;
		logic [2:0]  pri;
		logic [4:0]  typ;
	} entry_t;

	// One result as it leaves the block.
	typedef struct packed {
		logic [63:0] value;
		logic [2:0]  pri;
		logic [4:0]  typ;
		logic        run_last;
		logic        done;
		logic        ovf;
	} res_t;

endpackage

// File: src/itp_front.sv
module itp_front import itp_pkg::*; (
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] token_value,
	input  logic [2:0]  token_priority,
	input  logic [4:0]  token_type,
	input  logic        expr_end,
	input  logic        q_full,
	output logic        q_push,
	output cmd_t        q_cmd
);

	// The front stalls only while the queue has no free slot.
	assign in_stall = q_full;
	assign q_push = in_valid && !q_full;

	// Classify the token; the first matching rule decides.
	always_comb begin
		q_cmd.value = token_value;
		q_cmd.pri = token_priority;
		q_cmd.typ = token_type;
		q_cmd.last = expr_end;
		priority if (token_priority == PRI_NUMBER) begin
			q_cmd.kind = KIND_EMIT;
		end else if (token_priority == PRI_FUNCTION || token_type == TYPE_OPEN) begin
			q_cmd.kind = KIND_PUSH;
		end else if (token_priority <= PRI_OP_MAX) begin
			q_cmd.kind = KIND_OPER;
		end else if (token_type == TYPE_CLOSE) begin
			q_cmd.kind = KIND_CLOSE;
		end else begin
			q_cmd.kind = KIND_IGNORE;
		end
	end

endmodule

// File: src/itp_cmd_queue.sv
module itp_cmd_queue import itp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic rd_en,
	output logic rd_valid,
	output cmd_t rd_cmd
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd = slot_q[rd_ptr_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && rd_valid;

	// Pointer and fill count bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Queue slots hold payload only.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

// File: src/itp_back.sv
module itp_back import itp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  cmd_t q_cmd,
	output logic q_pop,
	output logic out_valid,
	input  logic out_stall,
	output res_t out_res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_EVAL = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam logic [1:0] MODE_OPER = 2'd0;
	localparam logic [1:0] MODE_CLOSE = 2'd1;
	localparam logic [1:0] MODE_FUNC = 2'd2;
	localparam logic [1:0] MODE_FLUSH = 2'd3;

	entry_t            mem [STACK_DEPTH];
	entry_t            rd_q;
	logic [1:0]        state_q;
	logic [1:0]        state_d;
	logic [1:0]        mode_q;
	logic [1:0]        mode_d;
	logic [SP_W-1:0]   sp_q;
	logic [SP_W-1:0]   sp_d;
	logic              ovf_q;
	cmd_t              cmd_q;
	cmd_t              cur;
	res_t              hold_q;
	logic              hold_v_q;
	res_t              out_q;
	logic              out_v_q;
	logic              take;
	logic              push_req;
	logic              sp_dec;
	logic              rd_req;
	logic              emit_req;
	logic              done_req;
	res_t              emit_d;
	logic              stack_full;
	logic              wr_en;
	logic              ovf_set;
	logic              ovf_clr;
	logic              out_free;
	logic              blk;
	logic [ADDR_W-1:0] rd_addr;

	assign cur = (state_q == ST_IDLE) ? q_cmd : cmd_q;
	assign stack_full = (sp_q == SP_W'(STACK_DEPTH));
	assign wr_en = push_req && !stack_full;
	assign ovf_set = push_req && stack_full;
	assign rd_addr = ADDR_W'(sp_q - 1'b1);

	// The pending result moves to the output register when the next one
	// appears or the request ends; hold everything while that cannot happen.
	assign out_free = !out_v_q || !out_stall;
	assign blk = (emit_req || done_req) && hold_v_q && !out_free;
	assign q_pop = take && !blk;

	// Sequencer: one stack read and one decision per popped entry.
	always_comb begin
		state_d = state_q;
		mode_d = mode_q;
		take = 1'b0;
		push_req = 1'b0;
		sp_dec = 1'b0;
		rd_req = 1'b0;
		emit_req = 1'b0;
		done_req = 1'b0;
		ovf_clr = 1'b0;
		emit_d.value = rd_q.value;
		emit_d.pri = rd_q.pri;
		emit_d.typ = rd_q.typ;
		emit_d.run_last = 1'b0;
		emit_d.done = 1'b0;
		emit_d.ovf = ovf_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					take = 1'b1;
					state_d = q_cmd.last ? ST_READ : ST_DONE;
					mode_d = MODE_FLUSH;
					unique case (q_cmd.kind)
						KIND_EMIT: begin
							emit_req = 1'b1;
							emit_d.value = q_cmd.value;
							emit_d.pri = q_cmd.pri;
							emit_d.typ = q_cmd.typ;
						end
						KIND_PUSH: begin
							push_req = 1'b1;
						end
						KIND_OPER: begin
							state_d = ST_READ;
							mode_d = MODE_OPER;
						end
						KIND_CLOSE: begin
							state_d = ST_READ;
							mode_d = MODE_CLOSE;
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				if (sp_q == '0) begin
					// Stack ran empty: finish the current step.
					if (mode_q == MODE_OPER) begin
						push_req = 1'b1;
					end
					if (mode_q == MODE_FLUSH) begin
						state_d = ST_DONE;
					end else begin
						state_d = cmd_q.last ? ST_READ : ST_DONE;
						mode_d = MODE_FLUSH;
					end
				end else begin
					rd_req = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				unique case (mode_q)
					MODE_OPER: begin
						// Open brackets stop an operator regardless of their priority.
						if (rd_q.typ != TYPE_OPEN && rd_q.pri > cmd_q.pri) begin
							emit_req = 1'b1;
							sp_dec = 1'b1;
							state_d = ST_READ;
						end else begin
							push_req = 1'b1;
							state_d = cmd_q.last ? ST_READ : ST_DONE;
							mode_d = MODE_FLUSH;
						end
					end
					MODE_CLOSE: begin
						sp_dec = 1'b1;
						state_d = ST_READ;
						if (rd_q.typ == TYPE_OPEN) begin
							mode_d = MODE_FUNC;
						end else begin
							emit_req = 1'b1;
						end
					end
					MODE_FUNC: begin
						// A function right under the matched bracket goes out too.
						if (rd_q.pri == PRI_FUNCTION) begin
							emit_req = 1'b1;
							sp_dec = 1'b1;
						end
						state_d = cmd_q.last ? ST_READ : ST_DONE;
						mode_d = MODE_FLUSH;
					end
					default: begin
						emit_req = 1'b1;
						sp_dec = 1'b1;
						state_d = ST_READ;
					end
				endcase
			end
			default: begin
				done_req = 1'b1;
				ovf_clr = cmd_q.last;
				state_d = ST_IDLE;
			end
		endcase
		sp_d = sp_q;
		if (wr_en) begin
			sp_d = sp_q + 1'b1;
		end else if (sp_dec) begin
			sp_d = sp_q - 1'b1;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= MODE_FLUSH;
			sp_q <= '0;
			ovf_q <= 1'b0;
			hold_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (!blk) begin
				state_q <= state_d;
				mode_q <= mode_d;
				sp_q <= sp_d;
				if (ovf_set) begin
					ovf_q <= 1'b1;
				end else if (ovf_clr) begin
					ovf_q <= 1'b0;
				end
				if (emit_req) begin
					hold_v_q <= 1'b1;
				end else if (done_req) begin
					hold_v_q <= 1'b0;
				end
			end
			if (out_free) begin
				out_v_q <= !blk && hold_v_q && (emit_req || done_req);
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (!blk) begin
			if (take) begin
				cmd_q <= q_cmd;
			end
			if (emit_req) begin
				hold_q <= emit_d;
			end
		end
		if (out_free && !blk && hold_v_q && (emit_req || done_req)) begin
			out_q <= '{value: hold_q.value, pri: hold_q.pri, typ: hold_q.typ,
				run_last: done_req, done: done_req && cmd_q.last, ovf: hold_q.ovf};
		end
	end

	// Stack memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en && !blk) begin
			mem[sp_q[ADDR_W-1:0]] <= '{value: cur.value, pri: cur.pri, typ: cur.typ};
		end
		if (rd_req && !blk) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign out_valid = out_v_q;
	assign out_res = out_q;

endmodule

// File: src/infix_to_postfix_converter_core.sv
// Infix to postfix converter. Each request carries one infix token; numbers
// come straight out, functions and open brackets are stacked, operators pop
// higher-priority entries before being stacked, a close bracket pops down to
// its open bracket (and a function just below it), and a token with expr_end
// set flushes the stack after its own work. run_last marks the final result
// of each request, expression_done the final result of a flush, and overflow
// reports the sticky flag for a push dropped on a full stack (32 entries),
// cleared once the flush finishes. The stack memory has one write port and
// a registered read, so every entry examined takes a read and a decision
// state. A number, a push or an ignored token takes the idle and done
// states. An operator or a close bracket adds both states for each entry
// it reads (each popped entry, a matched open bracket, and the entry that
// stops the scan or is checked for a function), plus a read state when the
// stack runs empty. An end mark adds both states per flushed entry plus a
// read state. A two-entry command queue lets new tokens be taken while the
// stack engine is busy, and an output register with a one-entry holding
// register lets one result wait at a stalled output before the engine stops.
module infix_to_postfix_converter_core import itp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] token_value,
	input  logic [2:0]  token_priority,
	input  logic [4:0]  token_type,
	input  logic        expr_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] out_value,
	output logic [2:0]  out_priority,
	output logic [4:0]  out_type,
	output logic        run_last,
	output logic        expression_done,
	output logic        overflow
);

	logic q_full;
	logic q_push;
	cmd_t q_wr_cmd;
	logic q_pop;
	logic q_valid;
	cmd_t q_rd_cmd;
	res_t res;

	itp_front u_front (
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.token_value    (token_value),
		.token_priority (token_priority),
		.token_type     (token_type),
		.expr_end       (expr_end),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_cmd          (q_wr_cmd)
	);

	itp_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_cmd   (q_wr_cmd),
		.full     (q_full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_cmd   (q_rd_cmd)
	);

	itp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_rd_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (res)
	);

	assign out_value = res.value;
	assign out_priority = res.pri;
	assign out_type = res.typ;
	assign run_last = res.run_last;
	assign expression_done = res.done;
	assign overflow = res.ovf;

endmodule

// File: src/itp_checker.sv
module itp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [63:0] token_value,
	input logic [2:0]  token_priority,
	input logic [4:0]  token_type,
	input logic        expr_end,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] out_value,
	input logic [2:0]  out_priority,
	input logic [4:0]  out_type,
	input logic        run_last,
	input logic        expression_done,
	input logic        overflow
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_value) && $stable(out_priority) &&
			$stable(out_type) && $stable(run_last) && $stable(expression_done) &&
			$stable(overflow))
		else $error("stalled result changed");

	// The end of a flush is always the final result of its request.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expression_done |-> run_last)
		else $error("expression_done without run_last");

	// Leaving reset, nothing is offered and the input is open.
	a_reset_clean: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid && !in_stall)
		else $error("block not clean after reset");

endmodule

bind infix_to_postfix_converter_core itp_checker u_itp_checker (.*);
